>>> hw/rtl/wbpe_pkg.sv
package wbpe_pkg;

   // record store and window geometry
   localparam int RECORD_DEPTH = 4096;
   localparam int BASELINE_LEN = 100;
   localparam int ADDR_W       = $clog2(RECORD_DEPTH);
   localparam int COUNT_W      = $clog2(RECORD_DEPTH + 1);
   localparam int WIN_W        = (COUNT_W > 13) ? COUNT_W : 13;
   localparam int SAMPLE_W     = 16;
   localparam int SUM_W        = 17;

   // floor division by the window length: multiply by a rounded-down
   // reciprocal, then one correction step
   localparam int          DIV_SHIFT = 31;
   localparam int          PROD_W    = SAMPLE_W + 32;
   localparam logic [31:0] DIV_MULT  = 32'((64'd1 << DIV_SHIFT) / BASELINE_LEN);
   localparam logic [SAMPLE_W-1:0] BL_VAL = SAMPLE_W'(BASELINE_LEN);

   // job queue between front and back
   localparam int JQ_DEPTH  = 2;
   localparam int JQ_PTR_W  = $clog2(JQ_DEPTH);
   localparam int JQ_FILL_W = $clog2(JQ_DEPTH + 1);

   // register reset values
   localparam logic [11:0] BASELINE_START_RST = 12'd450;
   localparam logic [11:0] SEARCH_START_RST   = 12'd400;
   localparam logic [12:0] SEARCH_END_RST     = 13'd3000;

   typedef enum logic [1:0] {
      CSR_BASELINE_START = 2'd0,
      CSR_SEARCH_START   = 2'd1,
      CSR_SEARCH_END     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [11:0] baseline_start;
      logic [11:0] search_start;
      logic [12:0] search_end;
   } csr_type;

   // one finished record waiting for the back end
   typedef struct packed {
      logic [COUNT_W-1:0] count;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_BASE_WALK,
      BK_BASE_DRAIN,
      BK_SRCH_WALK,
      BK_SRCH_DRAIN,
      BK_REPLY
   } back_state_type;

endpackage

>>> hw/rtl/wbpe_ram.sv
module wbpe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/wbpe_front.sv
module wbpe_front
   import wbpe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic                last_sample,
   output logic                wr_en,
   output logic [ADDR_W-1:0]   wr_addr,
   output logic [SAMPLE_W-1:0] wr_data,
   output logic                push,
   output job_type             push_job
);

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               room;
   logic [COUNT_W-1:0] count_next;

   // store while there is room; samples past the end are dropped
   assign room       = count_ff < COUNT_W'(RECORD_DEPTH);
   assign count_next = count_ff + COUNT_W'(room);
   assign wr_en      = take & room;
   assign wr_addr    = count_ff[ADDR_W-1:0];
   assign wr_data    = sample;

   // final word closes the record and hands it to the back end
   assign push           = take & last_sample;
   assign push_job.count = count_next;

   always_comb begin
      count_in = count_ff;
      if (take) begin
         count_in = last_sample ? '0 : count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> hw/rtl/wbpe_job_fifo.sv
module wbpe_job_fifo
   import wbpe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type pop_job,
   output logic    not_empty
);

   job_type              entry_ff [JQ_DEPTH];
   logic [JQ_PTR_W-1:0]  wr_ptr_ff;
   logic [JQ_PTR_W-1:0]  wr_ptr_in;
   logic [JQ_PTR_W-1:0]  rd_ptr_ff;
   logic [JQ_PTR_W-1:0]  rd_ptr_in;
   logic [JQ_FILL_W-1:0] fill_ff;
   logic [JQ_FILL_W-1:0] fill_in;
   logic                 full;

   assign not_empty = fill_ff != '0;
   assign full      = fill_ff == JQ_FILL_W'(JQ_DEPTH);
   assign pop_job   = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("job queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("job queue read while empty");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      !(fill_ff > JQ_FILL_W'(JQ_DEPTH)))
      else $error("job queue fill count beyond its depth");
`endif

endmodule

>>> hw/rtl/wbpe_back.sv
module wbpe_back
   import wbpe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  csr_type             csr,
   input  logic                job_valid,
   input  job_type             job,
   output logic                pop,
   output logic                rd_en,
   output logic [ADDR_W-1:0]   rd_addr,
   input  logic [SAMPLE_W-1:0] rd_data,
   output logic                active,
   output logic                rsp_valid,
   output logic [SAMPLE_W-1:0] rsp_baseline,
   output logic [SAMPLE_W-1:0] rsp_amplitude
);

   back_state_type state_ff;
   back_state_type state_in;

   logic [WIN_W-1:0]   idx_ff;
   logic [WIN_W-1:0]   idx_in;
   logic [WIN_W-1:0]   base_end_ff;
   logic [WIN_W-1:0]   base_end_in;
   logic [WIN_W-1:0]   srch_end_ff;
   logic [WIN_W-1:0]   srch_end_in;
   logic [COUNT_W-1:0] cnt_ff;

   // pipeline flags
   logic rd_vld_ff;
   logic p1_vld_ff;
   logic p2_vld_ff;
   logic p3_vld_ff;
   logic dev_vld_ff;

   // baseline datapath
   logic [PROD_W-1:0]     prod_ff;
   logic [SAMPLE_W-1:0]   smp1_ff;
   logic [SAMPLE_W-1:0]   q2_ff;
   logic [SAMPLE_W-1:0]   smp2_ff;
   logic [SAMPLE_W-1:0]   q3_ff;
   logic [SAMPLE_W-1:0]   smp3_ff;
   logic [SAMPLE_W-1:0]   qbl3_ff;
   logic [2*SAMPLE_W-1:0] qbl_wide;
   logic [SAMPLE_W-1:0]   rem;
   logic                  fix;
   logic [SUM_W-1:0]      acc_ff;
   logic [SUM_W-1:0]      acc_in;

   // search datapath
   logic [SUM_W-1:0] smp_ext;
   logic [SUM_W-1:0] dev_in;
   logic [SUM_W-1:0] dev_ff;
   logic [SUM_W-1:0] peak_ff;
   logic [SUM_W-1:0] peak_in;

   logic             base_ph;
   logic             walking;
   logic             issue;
   logic             pipe_busy;
   logic             load_srch;
   logic [WIN_W-1:0] end_sel;
   logic [WIN_W-1:0] cnt_w;
   logic [WIN_W-1:0] base_lim;
   logic [WIN_W-1:0] srch_lim;

   // windows clipped to the samples received
   assign cnt_w       = WIN_W'(job.count);
   assign base_lim    = WIN_W'(csr.baseline_start) + WIN_W'(BASELINE_LEN);
   assign srch_lim    = WIN_W'(csr.search_end);
   assign base_end_in = (base_lim < cnt_w) ? base_lim : cnt_w;
   assign srch_end_in = (srch_lim < cnt_w) ? srch_lim : cnt_w;

   assign base_ph   = (state_ff == BK_BASE_WALK) || (state_ff == BK_BASE_DRAIN);
   assign end_sel   = base_ph ? base_end_ff : srch_end_ff;
   assign pipe_busy = rd_vld_ff | p1_vld_ff | p2_vld_ff | p3_vld_ff | dev_vld_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) state_in = BK_BASE_WALK;
         end
         BK_BASE_WALK: begin
            if (idx_ff >= base_end_ff) state_in = BK_BASE_DRAIN;
         end
         BK_BASE_DRAIN: begin
            if (!pipe_busy) state_in = BK_SRCH_WALK;
         end
         BK_SRCH_WALK: begin
            if (idx_ff >= srch_end_ff) state_in = BK_SRCH_DRAIN;
         end
         BK_SRCH_DRAIN: begin
            if (!pipe_busy) state_in = BK_REPLY;
         end
         BK_REPLY: begin
            state_in = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      pop       = 1'b0;
      walking   = 1'b0;
      load_srch = 1'b0;
      rsp_valid = 1'b0;
      active    = 1'b1;
      case (state_ff)
         BK_IDLE: begin
            active = 1'b0;
            pop    = job_valid;
         end
         BK_BASE_WALK, BK_SRCH_WALK: begin
            walking = 1'b1;
         end
         BK_BASE_DRAIN: begin
            load_srch = !pipe_busy;
         end
         BK_SRCH_DRAIN: begin
         end
         BK_REPLY: begin
            rsp_valid = 1'b1;
         end
         default: begin
            active = 1'b0;
         end
      endcase
   end

   // walk index: one store read per cycle
   assign issue   = walking && (idx_ff < end_sel);
   assign rd_en   = issue;
   assign rd_addr = idx_ff[ADDR_W-1:0];

   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = WIN_W'(csr.baseline_start);
      end else if (load_srch) begin
         idx_in = WIN_W'(csr.search_start);
      end else if (issue) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   // baseline: quotient estimate, one low by at most one, then corrected
   assign qbl_wide = {{SAMPLE_W{1'b0}}, q2_ff} * {{SAMPLE_W{1'b0}}, BL_VAL};
   assign rem      = smp3_ff - qbl3_ff;
   assign fix      = rem >= BL_VAL;

   always_comb begin
      acc_in = acc_ff;
      if (pop) begin
         acc_in = '0;
      end else if (p3_vld_ff) begin
         acc_in = acc_ff + SUM_W'(q3_ff) + SUM_W'(fix);
      end
   end

   // search: absolute deviation, then running maximum
   assign smp_ext = SUM_W'(rd_data);
   assign dev_in  = (smp_ext >= acc_ff) ? smp_ext - acc_ff : acc_ff - smp_ext;

   always_comb begin
      peak_in = peak_ff;
      if (pop) begin
         peak_in = '0;
      end else if (dev_vld_ff && (dev_ff > peak_ff)) begin
         peak_in = dev_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_IDLE;
         rd_vld_ff  <= 1'b0;
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         p3_vld_ff  <= 1'b0;
         dev_vld_ff <= 1'b0;
         acc_ff     <= '0;
         peak_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= issue;
         p1_vld_ff  <= rd_vld_ff & base_ph;
         p2_vld_ff  <= p1_vld_ff;
         p3_vld_ff  <= p2_vld_ff;
         dev_vld_ff <= rd_vld_ff & !base_ph;
         acc_ff     <= acc_in;
         peak_ff    <= peak_in;
      end
   end

   // job bounds and datapath
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (pop) begin
         base_end_ff <= base_end_in;
         srch_end_ff <= srch_end_in;
         cnt_ff      <= job.count;
      end
      prod_ff <= PROD_W'(rd_data) * PROD_W'(DIV_MULT);
      smp1_ff <= rd_data;
      q2_ff   <= prod_ff[DIV_SHIFT +: SAMPLE_W];
      smp2_ff <= smp1_ff;
      q3_ff   <= q2_ff;
      smp3_ff <= smp2_ff;
      qbl3_ff <= qbl_wide[SAMPLE_W-1:0];
      dev_ff  <= dev_in;
   end

   assign rsp_baseline  = acc_ff[SAMPLE_W-1:0];
   assign rsp_amplitude = peak_ff[SAMPLE_W-1:0];

`ifndef NO_ASSERTIONS
   a_reply_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_reply_flushed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !pipe_busy)
      else $error("result given while the datapath still holds words");

   a_read_in_record: assert property (@(posedge clock) disable iff (reset)
      issue |-> (idx_ff < WIN_W'(cnt_ff)))
      else $error("store read beyond the received samples");
`endif

endmodule

>>> hw/rtl/waveform_baseline_peak_extractor.sv
// Baseline and peak-deviation extractor for one digitiser record.
// Input: a sample word is taken on each rising edge with start high and busy
// low; last_sample on the word closes the record. Samples load one a cycle;
// words beyond the store depth are dropped but the closing flag is honoured.
// After the closing word busy rises; the back end walks the clipped baseline
// window (Lb reads), drains, then walks the clipped search window (Ls reads),
// one store read a cycle on the single read port. The result is on rsp_valid
// for exactly one cycle, with rsp_baseline and rsp_amplitude; busy falls
// after that cycle, so the next record can start only after the result.
// The receiver cannot stall: the result is simply presented for one cycle.
// Configuration: csr_ready is always high; write only while busy is low.
// Index 0 baseline_start, 1 search_start, 2 search_end; others are ignored.
// Reset (synchronous, active high) empties the record, the job queue and the
// back end, and loads 450, 400 and 3000 into the registers. The store itself
// needs no clearing: only words of the current record are ever read.
module waveform_baseline_peak_extractor
   import wbpe_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_last_sample,
   output logic                rsp_valid,
   output logic [SAMPLE_W-1:0] rsp_baseline,
   output logic [SAMPLE_W-1:0] rsp_amplitude,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [12:0]         csr_data
);

   csr_type csr_ff;
   csr_type csr_in;

   logic                take;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [SAMPLE_W-1:0] wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   logic                push;
   job_type             push_job;
   logic                pop;
   job_type             pop_job;
   logic                job_pending;
   logic                back_active;

   assign take      = start & !busy;
   assign busy      = job_pending | back_active;
   assign csr_ready = 1'b1;

   // configuration registers
   always_comb begin
      csr_in = csr_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_BASELINE_START: csr_in.baseline_start = csr_data[11:0];
            CSR_SEARCH_START:   csr_in.search_start   = csr_data[11:0];
            CSR_SEARCH_END:     csr_in.search_end     = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.baseline_start <= BASELINE_START_RST;
         csr_ff.search_start   <= SEARCH_START_RST;
         csr_ff.search_end     <= SEARCH_END_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // front: stores the record
   wbpe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .sample      (req_sample),
      .last_sample (req_last_sample),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .push        (push),
      .push_job    (push_job)
   );

   // record store
   wbpe_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RECORD_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // finished records waiting for the back end
   wbpe_job_fifo u_jobs (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .pop_job   (pop_job),
      .not_empty (job_pending)
   );

   // back: baseline and peak walks
   wbpe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr           (csr_ff),
      .job_valid     (job_pending),
      .job           (pop_job),
      .pop           (pop),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .active        (back_active),
      .rsp_valid     (rsp_valid),
      .rsp_baseline  (rsp_baseline),
      .rsp_amplitude (rsp_amplitude)
   );

endmodule

>>> tb/tb_waveform_baseline_peak_extractor.sv
module tb_waveform_baseline_peak_extractor;
   import wbpe_pkg::*;

   // spare register index, outside the map: writes to it must change nothing
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // shapes of generated records
   localparam int SHAPE_NOISE = 0;
   localparam int SHAPE_PULSE = 1;
   localparam int SHAPE_RAILS = 2;

   localparam int WORD_TARGET   = 1600;
   localparam int RECORD_TARGET = 48;
   localparam int SETTLE_CYCLES = 32;
   localparam int CYCLE_LIMIT   = 2000000;

   typedef struct packed {
      logic [SAMPLE_W-1:0] baseline;
      logic [SAMPLE_W-1:0] amplitude;
   } height_type;

   // one row of the directed table: either a register setting or a word
   typedef struct packed {
      bit                  is_cfg;
      logic [12:0]         bs;
      logic [12:0]         ss;
      logic [12:0]         se;
      logic [SAMPLE_W-1:0] word;
      logic                last;
      bit                  typed;
      logic [SAMPLE_W-1:0] bl;
      logic [SAMPLE_W-1:0] amp;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [SAMPLE_W-1:0] req_sample;
   logic                req_last_sample;
   logic                rsp_valid;
   logic [SAMPLE_W-1:0] rsp_baseline;
   logic [SAMPLE_W-1:0] rsp_amplitude;
   logic                csr_valid;
   logic                csr_ready;
   logic [1:0]          csr_index;
   logic [12:0]         csr_data;

   // predictor state: own copy of the record and the registers
   logic [SAMPLE_W-1:0] record_copy [RECORD_DEPTH];
   int unsigned         stored;
   int unsigned         cfg_bs;
   int unsigned         cfg_ss;
   int unsigned         cfg_se;

   height_type          pending_heights [$];
   height_type          want_h;
   dir_row_type         dir_rows [$];
   int                  faults;
   bit                  calm;
   int unsigned         cycle_count;

   waveform_baseline_peak_extractor dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_baseline    (rsp_baseline),
      .rsp_amplitude   (rsp_amplitude),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // store one word; on the closing word work out baseline and amplitude
   task automatic absorb_word(input logic [SAMPLE_W-1:0] s, input logic l,
                              output bit done, output height_type h);
      int unsigned i;
      int unsigned stop;
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] peak;
      logic [SUM_W-1:0] dev;
      logic [SUM_W-1:0] v;
      begin
         done = 1'b0;
         h    = '0;
         if (stored < RECORD_DEPTH) begin
            record_copy[stored] = s;
            stored++;
         end
         if (l) begin
            sum  = '0;
            peak = '0;
            // baseline window, clipped to the words held
            stop = cfg_bs + BASELINE_LEN;
            if (stop > stored) stop = stored;
            for (i = cfg_bs; i < stop; i++)
               sum = sum + SUM_W'(record_copy[i] / BASELINE_LEN);
            // search window, clipped likewise
            stop = cfg_se;
            if (stop > stored) stop = stored;
            for (i = cfg_ss; i < stop; i++) begin
               v   = {1'b0, record_copy[i]};
               dev = (v >= sum) ? v - sum : sum - v;
               if (dev > peak) peak = dev;
            end
            h.baseline  = sum[SAMPLE_W-1:0];
            h.amplitude = peak[SAMPLE_W-1:0];
            done   = 1'b1;
            stored = 0;
         end
      end
   endtask

   // offer one word and hold it until busy is low at an edge
   task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic l, input bit typed,
                            input logic [SAMPLE_W-1:0] bl, input logic [SAMPLE_W-1:0] amp);
      bit         done;
      height_type h;
      begin
         start           <= 1'b1;
         req_sample      <= s;
         req_last_sample <= l;
         @(posedge clock);
         while (busy) @(posedge clock);
         absorb_word(s, l, done, h);
         if (done) begin
            if (typed) begin
               h.baseline  = bl;
               h.amplitude = amp;
            end
            pending_heights.push_back(h);
         end
      end
   endtask

   // random sender gap unless calm: each cycle idle with a chance of 28 in a hundred
   task automatic idle_gap();
      begin
         if (!calm) begin
            while ($urandom_range(0, 99) < 28) begin
               start <= 1'b0;
               @(posedge clock);
            end
         end
      end
   endtask

   // hold off until every result is in and the back end has gone quiet
   task automatic settle();
      begin
         start <= 1'b0;
         while (pending_heights.size() != 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         while (busy) @(posedge clock);
      end
   endtask

   // write all three registers, then a word to the spare index
   task automatic write_regs(input logic [12:0] bs, input logic [12:0] ss,
                             input logic [12:0] se);
      int          k;
      logic [1:0]  widx;
      logic [12:0] wval;
      begin
         for (k = 0; k < 4; k++) begin
            case (k)
               0: begin
                  widx = CSR_BASELINE_START;
                  wval = bs;
               end
               1: begin
                  widx = CSR_SEARCH_START;
                  wval = ss;
               end
               2: begin
                  widx = CSR_SEARCH_END;
                  wval = se;
               end
               default: begin
                  widx = CSR_SPARE;
                  wval = 13'($urandom);
               end
            endcase
            csr_valid <= 1'b1;
            csr_index <= widx;
            csr_data  <= wval;
            @(posedge clock);
            while (!csr_ready) @(posedge clock);
            case (widx)
               CSR_BASELINE_START: cfg_bs = wval[11:0];
               CSR_SEARCH_START:   cfg_ss = wval[11:0];
               CSR_SEARCH_END:     cfg_se = wval[12:0];
               default: ;
            endcase
         end
         csr_valid <= 1'b0;
      end
   endtask

   // one whole record of generated words
   task automatic send_record(input int len, input int shape);
      int                  j;
      int                  pulse_at;
      logic [SAMPLE_W-1:0] level;
      logic [SAMPLE_W-1:0] s;
      begin
         level    = SAMPLE_W'($urandom_range(0, 65535));
         pulse_at = $urandom_range(0, len - 1);
         for (j = 0; j < len; j++) begin
            case (shape)
               SHAPE_PULSE: begin
                  s = level + SAMPLE_W'($urandom_range(0, 15));
                  if (j == pulse_at) s = SAMPLE_W'($urandom);
               end
               SHAPE_RAILS: begin
                  s = SAMPLE_W'($urandom_range(0, 3));
                  if ($urandom_range(0, 1)) s = ~s;
               end
               default: s = SAMPLE_W'($urandom);
            endcase
            idle_gap();
            send_word(s, (j == len - 1), 1'b0, '0, '0);
         end
      end
   endtask

   task automatic dir_cfg(input logic [12:0] bs, input logic [12:0] ss, input logic [12:0] se);
      dir_row_type r;
      begin
         r        = '0;
         r.is_cfg = 1'b1;
         r.bs     = bs;
         r.ss     = ss;
         r.se     = se;
         dir_rows.push_back(r);
      end
   endtask

   task automatic dir_word(input logic [SAMPLE_W-1:0] w, input logic l, input bit typed,
                           input logic [SAMPLE_W-1:0] bl, input logic [SAMPLE_W-1:0] amp);
      dir_row_type r;
      begin
         r       = '0;
         r.word  = w;
         r.last  = l;
         r.typed = typed;
         r.bl    = bl;
         r.amp   = amp;
         dir_rows.push_back(r);
      end
   endtask

   // result checker: every strobe is matched against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_heights.size() == 0) begin
            $display("%0t: unexpected result baseline %0d amplitude %0d",
                     $time, rsp_baseline, rsp_amplitude);
            faults++;
         end else begin
            want_h = pending_heights.pop_front();
            if (rsp_baseline !== want_h.baseline) begin
               $display("%0t: baseline expected %0d actual %0d",
                        $time, want_h.baseline, rsp_baseline);
               faults++;
            end
            if (rsp_amplitude !== want_h.amplitude) begin
               $display("%0t: amplitude expected %0d actual %0d",
                        $time, want_h.amplitude, rsp_amplitude);
               faults++;
            end
         end
      end
   end

   // run guard
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_waveform_baseline_peak_extractor: errors");
      $finish;
   end

   initial begin
      int          n;
      int          words;
      int          records;
      int          len;
      int          shape;
      int          pick;
      int          ssv;
      dir_row_type r;

      faults          = 0;
      calm            = 1'b0;
      stored          = 0;
      cfg_bs          = BASELINE_START_RST;
      cfg_ss          = SEARCH_START_RST;
      cfg_se          = SEARCH_END_RST;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_sample      <= '0;
      req_last_sample <= 1'b0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_BASELINE_START;
      csr_data        <= '0;

      // directed table
      // after reset both windows lie past a short record
      dir_word(16'hFFFF, 1'b1, 1'b1, 16'd0, 16'd0);
      dir_word(16'h0000, 1'b0, 1'b0, '0, '0);
      dir_word(16'h1234, 1'b1, 1'b1, 16'd0, 16'd0);
      // widest windows from the first word
      dir_cfg(13'd0, 13'd0, 13'd4096);
      dir_word(16'hFFFF, 1'b1, 1'b1, 16'd655, 16'd64880);
      dir_word(16'd99, 1'b1, 1'b1, 16'd0, 16'd99);
      dir_word(16'h0000, 1'b0, 1'b0, '0, '0);
      dir_word(16'hFFFF, 1'b0, 1'b0, '0, '0);
      dir_word(16'h8000, 1'b1, 1'b0, '0, '0);
      dir_word(16'h0000, 1'b1, 1'b1, 16'd0, 16'd0);
      // empty search window over a filled record
      dir_cfg(13'd1, 13'd2, 13'd2);
      dir_word(16'hFFFF, 1'b0, 1'b0, '0, '0);
      dir_word(16'hFFFF, 1'b0, 1'b0, '0, '0);
      dir_word(16'hFFFF, 1'b1, 1'b1, 16'd1310, 16'd0);
      // all-ones register data, masked to width; windows off the end
      dir_cfg(13'h1FFF, 13'h1FFF, 13'h1FFF);
      dir_word(16'hAAAA, 1'b0, 1'b0, '0, '0);
      dir_word(16'h5555, 1'b1, 1'b1, 16'd0, 16'd0);
      // search end cuts the record short
      dir_cfg(13'd0, 13'd1, 13'd3);
      dir_word(16'h0000, 1'b0, 1'b0, '0, '0);
      dir_word(16'hFFFF, 1'b0, 1'b0, '0, '0);
      dir_word(16'h0000, 1'b0, 1'b0, '0, '0);
      dir_word(16'hFFFF, 1'b1, 1'b0, '0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < dir_rows.size(); n++) begin
         r = dir_rows[n];
         if (r.is_cfg) begin
            settle();
            write_regs(r.bs, r.ss, r.se);
         end else begin
            idle_gap();
            send_word(r.word, r.last, r.typed, r.bl, r.amp);
         end
      end

      // long record under the reset windows
      settle();
      write_regs(13'(BASELINE_START_RST), 13'(SEARCH_START_RST), SEARCH_END_RST);
      send_record(560, SHAPE_PULSE);

      // record longer than the store: the tail is dropped, the flag still closes it
      settle();
      write_regs(13'd3996, 13'd3990, 13'd4096);
      send_record(RECORD_DEPTH + 4, SHAPE_NOISE);

      // random records, a fresh register setting every few
      words   = 0;
      records = 0;
      while (words < WORD_TARGET || records < RECORD_TARGET) begin
         calm = (records >= 12 && records < 20);
         if (records % 6 == 0) begin
            settle();
            pick = $urandom_range(0, 9);
            case (pick)
               0: write_regs({1'($urandom), 12'd0}, 13'd0, 13'd4096);
               1: write_regs(13'h1FFF, 13'h1FFF, 13'h1FFF);
               2: write_regs(13'd0, 13'd0, 13'd0);
               default: begin
                  ssv = $urandom_range(0, 60);
                  write_regs({1'($urandom), 12'($urandom_range(0, 40))},
                             {1'($urandom), 12'(ssv)},
                             13'($urandom_range(ssv, ssv + 100)));
               end
            endcase
         end else if ($urandom_range(0, 9) == 0) begin
            // sender waits for the back end to empty
            settle();
         end
         if ($urandom_range(0, 19) == 0)
            len = 1;
         else if ($urandom_range(0, 99) < 60)
            len = $urandom_range(1, 30);
         else
            len = $urandom_range(80, 160);
         shape = $urandom_range(SHAPE_NOISE, SHAPE_RAILS);
         send_record(len, shape);
         words += len;
         records++;
      end
      calm = 1'b0;

      settle();
      if (faults == 0 && pending_heights.size() == 0) begin
         $display("tb_waveform_baseline_peak_extractor: clean");
      end else begin
         $display("tb_waveform_baseline_peak_extractor: errors");
      end
      $finish;
   end

endmodule
